// ----- hdl/seven_segment_number_frame_writer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Seven-segment frame writer assertion macros
// Property wrappers shared by the frame writer RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_FRAME_WRITER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_FRAME_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define SSNFW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define SSNFW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSNFW_ASSERT_IMP(lbl, ante, cons, msg)
`define SSNFW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/ssnfw_pkg.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame writer package
// Sizes, command bytes, segment table and the sequencer microprogram.
// ----------------------------------------------------------------------------
package ssnfw_pkg;

  localparam int MAX_DIGITS   = 6;
  localparam int NUM_DISPLAYS = 3;

  localparam int VAL_W     = 20;
  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h8A;
  localparam logic [7:0] POINT_BIT = 8'h80;

  // Reciprocal of ten scaled by 2^23; exact for every 20-bit dividend.
  localparam logic [VAL_W-1:0] RECIP_TEN = 20'hCCCCD;
  localparam int               RECIP_SH  = 23;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_DIV  = 3'd1;
  localparam step_t STEP_DATA = 3'd2;
  localparam step_t STEP_ADDR = 3'd3;
  localparam step_t STEP_DIG  = 3'd4;
  localparam step_t STEP_CTRL = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_DIV,
    OP_EMIT_DATA,
    OP_EMIT_ADDR,
    OP_EMIT_DIG,
    OP_EMIT_CTRL
  } op_e;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_LOAD,
    JC_DIV_MORE,
    JC_NO_DIGITS,
    JC_DIG_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Microprogram: load, divide MAX_DIGITS times, then emit the three frames.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      STEP_IDLE: w = '{op: OP_LOAD,      cond: JC_NO_LOAD,   target: STEP_IDLE};
      STEP_DIV:  w = '{op: OP_DIV,       cond: JC_DIV_MORE,  target: STEP_DIV};
      STEP_DATA: w = '{op: OP_EMIT_DATA, cond: JC_NEVER,     target: STEP_IDLE};
      STEP_ADDR: w = '{op: OP_EMIT_ADDR, cond: JC_NO_DIGITS, target: STEP_CTRL};
      STEP_DIG:  w = '{op: OP_EMIT_DIG,  cond: JC_DIG_MORE,  target: STEP_DIG};
      STEP_CTRL: w = '{op: OP_EMIT_CTRL, cond: JC_ALWAYS,    target: STEP_IDLE};
      default:   w = '{op: OP_LOAD,      cond: JC_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] seg_lut(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'b0011_1111;
      4'd1:    p = 8'b0000_0110;
      4'd2:    p = 8'b0101_1011;
      4'd3:    p = 8'b0100_1111;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b0110_1101;
      4'd6:    p = 8'b0111_1101;
      4'd7:    p = 8'b0000_0111;
      4'd8:    p = 8'b0111_1111;
      4'd9:    p = 8'b0110_0111;
      default: p = 8'b0000_0000;
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/ssnfw_div10.sv -----
// ----------------------------------------------------------------------------
// Divide by ten
// Quotient and remainder of a 20-bit value by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ssnfw_div10 (
  input  logic [ssnfw_pkg::VAL_W-1:0] dividend_i,
  output logic [ssnfw_pkg::VAL_W-1:0] quotient_o,
  output logic [3:0]                  remainder_o
);

  logic [2*ssnfw_pkg::VAL_W-1:0] prod;
  logic [ssnfw_pkg::VAL_W-1:0]   quot;
  logic [ssnfw_pkg::VAL_W-1:0]   quot_x10;
  logic [ssnfw_pkg::VAL_W-1:0]   rem_full;

  assign prod = (2*ssnfw_pkg::VAL_W)'(dividend_i)
              * (2*ssnfw_pkg::VAL_W)'(ssnfw_pkg::RECIP_TEN);
  assign quot = ssnfw_pkg::VAL_W'(prod >> ssnfw_pkg::RECIP_SH);

  // Times ten as two shifted copies.
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = dividend_i - quot_x10;

  assign quotient_o  = quot;
  assign remainder_o = rem_full[3:0];

endmodule

// ----- hdl/seven_segment_number_frame_writer_core.sv -----
// ----------------------------------------------------------------------------
// Seven-segment number frame writer
// Turns a number request into the byte stream for a two-wire display module.
// ----------------------------------------------------------------------------
// One request is taken while the sequencer is idle, then it divides by ten once
// per decimal digit place (six in all), and then issues one beat per cycle
// while the output is not stalled: the data command, the address, count digit
// patterns and the display control command. The final beat may still wait in
// the output register while the next request is taken. A request for a display
// that does not exist is taken and dropped without producing any beat.
`include "seven_segment_number_frame_writer_core_defines.svh"

module seven_segment_number_frame_writer_core (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] display_select_i,
  input  logic [2:0] start_grid_i,
  input  logic       right_align_i,
  input  logic [19:0] number_value_i,
  input  logic [2:0] digit_count_i,
  input  logic       colon_on_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] target_display_o,
  output logic [7:0] bus_byte_o,
  output logic       frame_start_o,
  output logic       frame_end_o,
  output logic       last_byte_o
);

  // Sequencer state.
  ssnfw_pkg::step_t                   step_q, step_d;
  logic [ssnfw_pkg::DIG_IDX_W-1:0]    div_cnt_q, div_cnt_d;
  logic [ssnfw_pkg::DIG_IDX_W-1:0]    dig_idx_q, dig_idx_d;
  logic [ssnfw_pkg::CNT_W-1:0]        sig_q, sig_d;

  // Request payload.
  logic [1:0]                         disp_q;
  logic [2:0]                         grid_q;
  logic                               ralign_q;
  logic [2:0]                         dcount_q;
  logic                               colon_q;
  logic [ssnfw_pkg::VAL_W-1:0]        work_q;
  logic [3:0]                         dig_q [ssnfw_pkg::MAX_DIGITS];

  // Output register.
  logic                               out_valid_q, out_valid_d;
  logic [1:0]                         out_disp_q;
  logic [7:0]                         out_byte_q, out_byte_d;
  logic                               out_fs_q, out_fs_d;
  logic                               out_fe_q, out_fe_d;
  logic                               out_lb_q, out_lb_d;

  ssnfw_pkg::ucode_t                  uc;
  logic                               disp_ok;
  logic                               in_accept;
  logic                               emit_op;
  logic                               out_load;
  logic                               jump;
  logic [ssnfw_pkg::VAL_W-1:0]        div_quot;
  logic [3:0]                         div_rem;
  logic [ssnfw_pkg::CNT_W-1:0]        count;
  logic [7:0]                         addr_byte;
  logic [7:0]                         dig_byte;

  localparam logic [ssnfw_pkg::DIG_IDX_W-1:0] DivLast =
    ssnfw_pkg::DIG_IDX_W'(ssnfw_pkg::MAX_DIGITS - 1);

  ssnfw_div10 u_div10 (
    .dividend_i  (work_q),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign uc         = ssnfw_pkg::ucode_rom(step_q);
  assign in_stall_o = (uc.op != ssnfw_pkg::OP_LOAD);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign disp_ok    = (32'(display_select_i) < 32'(ssnfw_pkg::NUM_DISPLAYS));

  assign emit_op  = (uc.op == ssnfw_pkg::OP_EMIT_DATA) || (uc.op == ssnfw_pkg::OP_EMIT_ADDR)
                 || (uc.op == ssnfw_pkg::OP_EMIT_DIG)  || (uc.op == ssnfw_pkg::OP_EMIT_CTRL);
  assign out_load = emit_op && (!out_valid_q || !out_stall_i);

  // A count of zero takes the significant digits; a count above MAX_DIGITS saturates.
  always_comb begin
    if (dcount_q == 3'd0) begin
      count = sig_q;
    end else if (32'(dcount_q) > ssnfw_pkg::MAX_DIGITS) begin
      count = ssnfw_pkg::CNT_W'(ssnfw_pkg::MAX_DIGITS);
    end else begin
      count = ssnfw_pkg::CNT_W'(dcount_q);
    end
  end

  assign addr_byte = ssnfw_pkg::CMD_ADDR + 8'(grid_q)
                   + (ralign_q ? (8'd1 - 8'(count)) : 8'd0);
  assign dig_byte  = ssnfw_pkg::seg_lut(dig_q[dig_idx_q])
                   | (colon_q ? ssnfw_pkg::POINT_BIT : 8'h00);

  always_comb begin
    case (uc.cond)
      ssnfw_pkg::JC_NEVER:     jump = 1'b0;
      ssnfw_pkg::JC_ALWAYS:    jump = 1'b1;
      ssnfw_pkg::JC_NO_LOAD:   jump = !(in_accept && disp_ok);
      ssnfw_pkg::JC_DIV_MORE:  jump = (div_cnt_q != DivLast);
      ssnfw_pkg::JC_NO_DIGITS: jump = (count == '0);
      ssnfw_pkg::JC_DIG_MORE:  jump = (dig_idx_q != '0);
      default:                 jump = 1'b1;
    endcase
  end

  // Next step, counters and output beat.
  always_comb begin
    step_d      = step_q;
    div_cnt_d   = div_cnt_q;
    dig_idx_d   = dig_idx_q;
    sig_d       = sig_q;
    out_byte_d  = ssnfw_pkg::CMD_DATA;
    out_fs_d    = 1'b1;
    out_fe_d    = 1'b1;
    out_lb_d    = 1'b0;

    if (!emit_op || out_load) begin
      step_d = jump ? uc.target : ssnfw_pkg::step_t'(step_q + 1'b1);
    end

    case (uc.op)
      ssnfw_pkg::OP_LOAD: begin
        div_cnt_d = '0;
        sig_d     = '0;
      end
      ssnfw_pkg::OP_DIV: begin
        // The highest place whose dividend is non-zero sets the digit count.
        if (work_q != '0) begin
          sig_d = ssnfw_pkg::CNT_W'(div_cnt_q) + 1'b1;
        end
        div_cnt_d = (div_cnt_q == DivLast) ? '0 : div_cnt_q + 1'b1;
      end
      ssnfw_pkg::OP_EMIT_DATA: begin
        out_byte_d = ssnfw_pkg::CMD_DATA;
      end
      ssnfw_pkg::OP_EMIT_ADDR: begin
        out_byte_d = addr_byte;
        out_fe_d   = (count == '0);
        if (out_load) begin
          dig_idx_d = ssnfw_pkg::DIG_IDX_W'(count - 1'b1);
        end
      end
      ssnfw_pkg::OP_EMIT_DIG: begin
        out_byte_d = dig_byte;
        out_fs_d   = 1'b0;
        out_fe_d   = (dig_idx_q == '0);
        if (out_load) begin
          dig_idx_d = dig_idx_q - 1'b1;
        end
      end
      ssnfw_pkg::OP_EMIT_CTRL: begin
        out_byte_d = ssnfw_pkg::CMD_CTRL;
        out_lb_d   = 1'b1;
      end
      default: begin
        step_d = ssnfw_pkg::STEP_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ssnfw_pkg::STEP_IDLE;
      div_cnt_q   <= '0;
      dig_idx_q   <= '0;
      sig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      div_cnt_q   <= div_cnt_d;
      dig_idx_q   <= dig_idx_d;
      sig_q       <= sig_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      disp_q   <= display_select_i;
      grid_q   <= start_grid_i;
      ralign_q <= right_align_i;
      dcount_q <= digit_count_i;
      colon_q  <= colon_on_i;
      work_q   <= number_value_i;
    end else if (uc.op == ssnfw_pkg::OP_DIV) begin
      work_q            <= div_quot;
      dig_q[div_cnt_q]  <= div_rem;
    end
    if (out_load) begin
      out_disp_q <= disp_q;
      out_byte_q <= out_byte_d;
      out_fs_q   <= out_fs_d;
      out_fe_q   <= out_fe_d;
      out_lb_q   <= out_lb_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign target_display_o = out_disp_q;
  assign bus_byte_o       = out_byte_q;
  assign frame_start_o    = out_fs_q;
  assign frame_end_o      = out_fe_q;
  assign last_byte_o      = out_lb_q;

  // A valid request starts the division pass on the next cycle.
  `SSNFW_ASSERT_NXT(a_accept_starts_div, in_accept && disp_ok, step_q == ssnfw_pkg::STEP_DIV, "accepted request did not start division")
  // The closing beat is always the display control command with a stop.
  `SSNFW_ASSERT_IMP(a_last_is_ctrl, out_valid_o && last_byte_o, (bus_byte_o == ssnfw_pkg::CMD_CTRL) && frame_end_o, "last beat is not a framed control command")
  // Digit beats never read past the digit count.
  `SSNFW_ASSERT_IMP(a_dig_in_range, step_q == ssnfw_pkg::STEP_DIG, ssnfw_pkg::CNT_W'(dig_idx_q) < count, "digit pointer beyond digit count")
  // The significant digit count never exceeds the digit store.
  `SSNFW_ASSERT_IMP(a_sig_bounded, 1'b1, 32'(sig_q) <= ssnfw_pkg::MAX_DIGITS, "significant digit count out of range")

endmodule

// ----- tb/sv/seven_segment_number_frame_writer_core_checker.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame writer checker
// Watches both channels, works out the beats each request must produce and
// compares every output beat, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_number_frame_writer_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  display_select_i,
  input  logic [2:0]  start_grid_i,
  input  logic        right_align_i,
  input  logic [19:0] number_value_i,
  input  logic [2:0]  digit_count_i,
  input  logic        colon_on_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  target_display_i,
  input  logic [7:0]  bus_byte_i,
  input  logic        frame_start_i,
  input  logic        frame_end_i,
  input  logic        last_byte_i,

  output int          fail_count_o,
  output int          beats_pending_o
);

  typedef struct packed {
    logic [1:0] display;
    logic [7:0] code;
    logic       opens;
    logic       closes;
    logic       final_beat;
  } frame_beat_t;

  logic [7:0]  digit_glyph [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                     8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
  frame_beat_t frame_beats_due [$];
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  // Queues the command, address, digit and control beats of one request.
  function automatic void queue_frame_beats(input logic [1:0]  disp,
                                            input logic [2:0]  grid,
                                            input logic        ralign,
                                            input logic [19:0] value,
                                            input logic [2:0]  requested,
                                            input logic        colon);
    int unsigned places;
    int unsigned rest;
    logic [31:0] grid_pos;
    logic [7:0]  glyphs [ssnfw_pkg::MAX_DIGITS];

    if (32'(disp) >= 32'(ssnfw_pkg::NUM_DISPLAYS)) return;

    places = 32'(requested);
    if (places == 0) begin
      rest = 32'(value);
      while (rest > 0) begin
        places++;
        rest = rest / 10;
      end
    end
    if (places > ssnfw_pkg::MAX_DIGITS) places = ssnfw_pkg::MAX_DIGITS;

    rest = 32'(value);
    for (int p = places; p > 0; p--) begin
      glyphs[p-1] = digit_glyph[rest % 10] | (colon ? ssnfw_pkg::POINT_BIT : 8'h00);
      rest = rest / 10;
    end

    // Right alignment counts back from the named grid; the byte wraps.
    grid_pos = 32'(grid);
    if (ralign) grid_pos = grid_pos + 1 - places;

    frame_beats_due.push_back('{disp, ssnfw_pkg::CMD_DATA, 1'b1, 1'b1, 1'b0});
    frame_beats_due.push_back('{disp, ssnfw_pkg::CMD_ADDR + grid_pos[7:0], 1'b1,
                                places == 0, 1'b0});
    for (int p = 0; p < places; p++)
      frame_beats_due.push_back('{disp, glyphs[p], 1'b0, p + 1 == places, 1'b0});
    frame_beats_due.push_back('{disp, ssnfw_pkg::CMD_CTRL, 1'b1, 1'b1, 1'b1});
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (!rst_ni) begin
      beats_pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        queue_frame_beats(display_select_i, start_grid_i, right_align_i,
                          number_value_i, digit_count_i, colon_on_i);
      if (out_valid_i && !out_stall_i) begin
        if (frame_beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual byte %0h to display %0d",
                   $time, bus_byte_i, target_display_i);
          mismatches++;
        end else begin
          want = frame_beats_due.pop_front();
          compare_field("target_display", 8'(want.display), 8'(target_display_i));
          compare_field("bus_byte", want.code, bus_byte_i);
          compare_field("frame_start", 8'(want.opens), 8'(frame_start_i));
          compare_field("frame_end", 8'(want.closes), 8'(frame_end_i));
          compare_field("last_byte", 8'(want.final_beat), 8'(last_byte_i));
        end
      end
      beats_pending_o <= frame_beats_due.size();
    end
  end

endmodule

// ----- tb/sv/seven_segment_number_frame_writer_core_tb.sv -----
// ----------------------------------------------------------------------------
// Seven-segment frame writer testbench
// Sends directed and random number requests under varying back-pressure and
// leaves the beat-by-beat checking to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seven_segment_number_frame_writer_core_tb;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int REQUESTS_SHOWN = 320;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  display_select_i = '0;
  logic [2:0]  start_grid_i = '0;
  logic        right_align_i = 1'b0;
  logic [19:0] number_value_i = '0;
  logic [2:0]  digit_count_i = '0;
  logic        colon_on_i = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  target_display_o;
  logic [7:0]  bus_byte_o;
  logic        frame_start_o;
  logic        frame_end_o;
  logic        last_byte_o;

  int          fail_count;
  int          beats_pending;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  logic        long_hold_req = 1'b0;
  logic        sender_paused = 1'b0;

  always #10 clk_i = ~clk_i;

  seven_segment_number_frame_writer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .display_select_i (display_select_i),
    .start_grid_i     (start_grid_i),
    .right_align_i    (right_align_i),
    .number_value_i   (number_value_i),
    .digit_count_i    (digit_count_i),
    .colon_on_i       (colon_on_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_display_o (target_display_o),
    .bus_byte_o       (bus_byte_o),
    .frame_start_o    (frame_start_o),
    .frame_end_o      (frame_end_o),
    .last_byte_o      (last_byte_o)
  );

  seven_segment_number_frame_writer_core_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .display_select_i (display_select_i),
    .start_grid_i     (start_grid_i),
    .right_align_i    (right_align_i),
    .number_value_i   (number_value_i),
    .digit_count_i    (digit_count_i),
    .colon_on_i       (colon_on_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_display_i (target_display_o),
    .bus_byte_i       (bus_byte_o),
    .frame_start_i    (frame_start_o),
    .frame_end_i      (frame_end_o),
    .last_byte_i      (last_byte_o),
    .fail_count_o     (fail_count),
    .beats_pending_o  (beats_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seven_segment_number_frame_writer_core_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the core backs up.
  always @(posedge clk_i) begin
    int   hold_left;
    logic hold_taken;
    if (!rst_ni) begin
      hold_left  = 0;
      hold_taken = 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // Offers one request, waits for it to be taken, then perhaps pauses.
  task automatic offer_request(input logic [1:0]  disp,
                               input logic [2:0]  grid,
                               input logic        ralign,
                               input logic [19:0] value,
                               input logic [2:0]  places,
                               input logic        colon);
    in_valid_i       <= 1'b1;
    display_select_i <= disp;
    start_grid_i     <= grid;
    right_align_i    <= ralign;
    number_value_i   <= value;
    digit_count_i    <= places;
    colon_on_i       <= colon;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sender_paused = ($urandom_range(99) < sender_idle_pct);
    if (sender_paused) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Mostly valid displays; values spread over every digit length and beyond.
  task automatic offer_random_request(output logic shown);
    logic [1:0]  disp;
    logic [19:0] value;
    disp = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
    case ($urandom_range(4))
      0:       value = 20'($urandom_range(9));
      1:       value = 20'($urandom_range(999));
      2:       value = 20'($urandom_range(99999));
      3:       value = 20'($urandom_range(999999));
      default: value = 20'($urandom);
    endcase
    offer_request(disp, 3'($urandom_range(7)), 1'($urandom_range(1)), value,
                  3'($urandom_range(7)), 1'($urandom_range(1)));
    shown = (disp != 2'd3);
  endtask

  initial begin
    int   shown_count;
    logic shown;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero digits, saturation, wrap-around, ignored displays.
    offer_request(2'd0, 3'd0, 1'b0, 20'd0,       3'd0, 1'b0);
    offer_request(2'd1, 3'd5, 1'b1, 20'd0,       3'd0, 1'b1);
    offer_request(2'd2, 3'd0, 1'b0, 20'd999999,  3'd0, 1'b0);
    offer_request(2'd0, 3'd0, 1'b0, 20'hFFFFF,   3'd0, 1'b1);
    offer_request(2'd1, 3'd2, 1'b0, 20'd123456,  3'd7, 1'b0);
    offer_request(2'd2, 3'd0, 1'b1, 20'd987654,  3'd6, 1'b1);
    offer_request(2'd0, 3'd3, 1'b1, 20'd42,      3'd2, 1'b0);
    offer_request(2'd1, 3'd0, 1'b0, 20'd5,       3'd3, 1'b0);
    offer_request(2'd2, 3'd1, 1'b0, 20'd9,       3'd1, 1'b1);
    offer_request(2'd0, 3'd4, 1'b0, 20'd10,      3'd0, 1'b0);
    offer_request(2'd3, 3'd0, 1'b0, 20'd123,     3'd3, 1'b0);
    offer_request(2'd3, 3'd7, 1'b1, 20'hFFFFF,   3'd7, 1'b1);
    offer_request(2'd1, 3'd6, 1'b0, 20'd7,       3'd1, 1'b0);
    offer_request(2'd2, 3'd7, 1'b1, 20'd8,       3'd4, 1'b1);
    offer_request(2'd0, 3'd7, 1'b0, 20'd314159,  3'd5, 1'b0);
    offer_request(2'd1, 3'd5, 1'b1, 20'd2718,    3'd0, 1'b0);
    offer_request(2'd0, 3'd1, 1'b0, 20'd60817,   3'd5, 1'b1);
    offer_request(2'd1, 3'd2, 1'b1, 20'd99999,   3'd0, 1'b0);
    offer_request(2'd2, 3'd3, 1'b0, 20'd100000,  3'd0, 1'b1);
    offer_request(2'd0, 3'd0, 1'b1, 20'd0,       3'd1, 1'b0);
    offer_request(2'd2, 3'd6, 1'b1, 20'd1000000, 3'd0, 1'b1);

    // Random part in three phases of back-pressure.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 29; receiver_idle_pct = 61; end
        1:       begin sender_idle_pct = 61; receiver_idle_pct = 29; end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
          long_hold_req    <= 1'b1;
        end
      endcase
      shown_count = 0;
      while (shown_count < REQUESTS_SHOWN / 3) begin
        offer_random_request(shown);
        if (shown) shown_count++;
      end
    end
    if (!sender_paused) in_valid_i <= 1'b0;

    // The pending count is registered and trails the requests and beats it counts.
    repeat (2) @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("seven_segment_number_frame_writer_core_tb passed");
    end else begin
      $display("seven_segment_number_frame_writer_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- seven_segment_number_frame_writer_core.f -----
+incdir+hdl
hdl/ssnfw_pkg.sv
hdl/ssnfw_div10.sv
hdl/seven_segment_number_frame_writer_core.sv
tb/sv/seven_segment_number_frame_writer_core_checker.sv
tb/sv/seven_segment_number_frame_writer_core_tb.sv
